@@ src/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the priority scheduler
// Process store geometry, transaction payload structs and saturation limits.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_PROCS = 32;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRIO_W = 8;
    localparam int CLK_W  = 22;
    localparam int SUM_W  = 27;
    localparam int PIDX_W = 5;

    localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Input transaction: one process
    typedef struct packed {
        logic [ARR_W-1:0]  arrival_time;
        logic [BUR_W-1:0]  burst_time;
        logic [PRIO_W-1:0] priority_req;
        logic              last_process;
    } sched_in_t;

    // Result transaction: one scheduled process
    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [CLK_W-1:0]  waiting_time;
        logic [CLK_W-1:0]  turnaround_time;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic              last_result;
    } sched_out_t;

    // One stored process entry
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
        logic [PRIO_W-1:0] prio;
    } proc_entry_t;

endpackage

@@ src/nps_proc_mem.sv @@
// ----------------------------------------------------------------------------
// nps_proc_mem: process store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module nps_proc_mem
    import nps_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  proc_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output proc_entry_t       rd_data
);

    proc_entry_t mem [MAX_PROCS];

    // Write one entry per load transaction
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read for the scan
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/nonpreemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: non-preemptive priority scheduling engine
// Loads a process set, then emits processes in completion order with times.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one process per transaction (arrival, burst, priority).
//   Loading takes one transaction per cycle while no pass runs. The transaction
//   flagged last_process closes the set and starts a scheduling pass; s_ready
//   stays low until the pass has emitted its last result.
//   Each decision scans the stored entries through one memory read port,
//   then decides in S_DECIDE. An idle clock jump to the next arrival costs
//   one more scan; a pick runs the update steps S_RUN1 to S_RUN3 to update
//   the clock and the running sums, and a pass repeats this for each process.
//   m_* channel delivers one result per pick through an output register; the
//   engine stalls on the final update step while the previous result waits.
//   Loading of the next set may begin while the final result is still held.
//   Reset (aresetn low, synchronous) empties the set and clears the clock,
//   the sums and m_valid; output data and store contents are left as they are.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sched_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output sched_out_t m_data
);

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_RUN1   = 6'b001000,
        S_RUN2   = 6'b010000,
        S_RUN3   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [CNT_W-1:0]     finished_reg, finished_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [SUM_W-1:0]     wsum_reg, wsum_next;
    logic [SUM_W-1:0]     tsum_reg, tsum_next;
    logic [MAX_PROCS-1:0] done_reg, done_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [ARR_W-1:0]     pick_arr_reg, pick_arr_next;
    logic [BUR_W-1:0]     pick_bur_reg, pick_bur_next;
    logic [CLK_W-1:0]     next_arr_reg, next_arr_next;
    logic [CLK_W-1:0]     wait_reg, wait_next;
    logic [CLK_W-1:0]     tat_reg, tat_next;
    logic                 m_valid_reg, m_valid_next;
    sched_out_t           m_data_reg, m_data_next;

    logic        load_acc;
    logic        wr_en;
    logic        issue;
    proc_entry_t wr_entry;
    proc_entry_t rd_entry;
    logic [CLK_W:0]   clk_sum;
    logic [SUM_W:0]   wsum_sum;
    logic [SUM_W:0]   tsum_sum;
    logic [SUM_W-1:0] tsum_sat;
    logic [CNT_W-1:0] finished_inc;

    assign s_ready  = (state_reg == S_LOAD);
    assign load_acc = s_valid && s_ready;
    assign wr_en    = load_acc && (loaded_reg < CNT_W'(MAX_PROCS));
    assign issue    = (state_reg == S_SCAN) && (scan_addr_reg < loaded_reg);

    assign wr_entry.arrival = s_data.arrival_time;
    assign wr_entry.burst   = s_data.burst_time;
    assign wr_entry.prio    = s_data.priority_req;

    nps_proc_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (scan_addr_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // Adders for the clock and the running sums
    assign clk_sum      = {1'b0, clock_reg} + {{(CLK_W-BUR_W+1){1'b0}}, pick_bur_reg};
    assign wsum_sum     = {1'b0, wsum_reg} + {{(SUM_W-CLK_W+1){1'b0}}, wait_reg};
    assign tsum_sum     = {1'b0, tsum_reg} + {{(SUM_W-CLK_W+1){1'b0}}, tat_reg};
    assign tsum_sat     = tsum_sum[SUM_W] ? SUM_MAX : tsum_sum[SUM_W-1:0];
    assign finished_inc = finished_reg + CNT_W'(1);

    // Sequencer: load, scan, decide, update
    always_comb begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        finished_next  = finished_reg;
        clock_next     = clock_reg;
        wsum_next      = wsum_reg;
        tsum_next      = tsum_reg;
        done_next      = done_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = issue;
        rd_idx_next    = scan_addr_reg[IDX_W-1:0];
        found_next     = found_reg;
        best_prio_next = best_prio_reg;
        pick_idx_next  = pick_idx_reg;
        pick_arr_next  = pick_arr_reg;
        pick_bur_next  = pick_bur_reg;
        next_arr_next  = next_arr_reg;
        wait_next      = wait_reg;
        tat_next       = tat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            S_LOAD: begin
                // Store the process and start a pass on the flagged one
                if (wr_en) begin
                    loaded_next = loaded_reg + CNT_W'(1);
                end
                if (load_acc && s_data.last_process) begin
                    state_next     = S_SCAN;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    next_arr_next  = CLOCK_MAX;
                end
            end
            S_SCAN: begin
                // Advance the read address and fold in the returned entry
                if (issue) begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (rd_vld_reg && !done_reg[rd_idx_reg]) begin
                    if ({{(CLK_W-ARR_W){1'b0}}, rd_entry.arrival} <= clock_reg) begin
                        if (!found_reg || (rd_entry.prio < best_prio_reg)) begin
                            found_next     = 1'b1;
                            best_prio_next = rd_entry.prio;
                            pick_idx_next  = rd_idx_reg;
                            pick_arr_next  = rd_entry.arrival;
                            pick_bur_next  = rd_entry.burst;
                        end
                    end else if ({{(CLK_W-ARR_W){1'b0}}, rd_entry.arrival}
                                 < next_arr_reg) begin
                        next_arr_next = {{(CLK_W-ARR_W){1'b0}}, rd_entry.arrival};
                    end
                end
                if (!issue && !rd_vld_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // Run the pick, or jump the clock to the next arrival and rescan
                if (found_reg) begin
                    state_next = S_RUN1;
                end else begin
                    clock_next     = next_arr_reg;
                    state_next     = S_SCAN;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    next_arr_next  = CLOCK_MAX;
                end
            end
            S_RUN1: begin
                wait_next  = clock_reg - {{(CLK_W-ARR_W){1'b0}}, pick_arr_reg};
                clock_next = clk_sum[CLK_W] ? CLOCK_MAX : clk_sum[CLK_W-1:0];
                state_next = S_RUN2;
            end
            S_RUN2: begin
                tat_next   = clock_reg - {{(CLK_W-ARR_W){1'b0}}, pick_arr_reg};
                wsum_next  = wsum_sum[SUM_W] ? SUM_MAX : wsum_sum[SUM_W-1:0];
                state_next = S_RUN3;
            end
            S_RUN3: begin
                // Hold until the output register is free, then emit
                if (!m_valid_reg || m_ready) begin
                    tsum_next                    = tsum_sat;
                    m_valid_next                 = 1'b1;
                    m_data_next.process_index    = PIDX_W'(pick_idx_reg);
                    m_data_next.waiting_time     = wait_reg;
                    m_data_next.turnaround_time  = tat_reg;
                    m_data_next.total_waiting    = wsum_reg;
                    m_data_next.total_turnaround = tsum_sat;
                    m_data_next.last_result      = (finished_inc == loaded_reg);
                    done_next[pick_idx_reg]      = 1'b1;
                    finished_next                = finished_inc;
                    if (finished_inc == loaded_reg) begin
                        // Drop the pass state, ready for a new set
                        state_next    = S_LOAD;
                        done_next     = '0;
                        loaded_next   = '0;
                        finished_next = '0;
                        clock_next    = '0;
                        wsum_next     = '0;
                        tsum_next     = '0;
                    end else begin
                        state_next     = S_SCAN;
                        scan_addr_next = '0;
                        found_next     = 1'b0;
                        next_arr_next  = CLOCK_MAX;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            finished_reg  <= '0;
            clock_reg     <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            done_reg      <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            finished_reg  <= finished_next;
            clock_reg     <= clock_next;
            wsum_reg      <= wsum_next;
            tsum_reg      <= tsum_next;
            done_reg      <= done_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        best_prio_reg <= best_prio_next;
        pick_idx_reg  <= pick_idx_next;
        pick_arr_reg  <= pick_arr_next;
        pick_bur_reg  <= pick_bur_next;
        next_arr_reg  <= next_arr_next;
        wait_reg      <= wait_next;
        tat_reg       <= tat_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
